>>> src/lfpr_pkg.sv
package lfpr_pkg;

   // frame geometry
   localparam int MaxFrame  = 64;
   localparam int ByteW     = 8;
   localparam int AddrW     = $clog2(MaxFrame);
   localparam int CountW    = $clog2(MaxFrame + 1);
   localparam int LenW      = 7;
   localparam int LenAdd    = 4;
   localparam int MinLen    = 11;
   localparam int XorFirst  = 2;
   localparam int TrailBytes = 3;

   // register indexes
   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] RegStartByte  = 2'd0;
   localparam logic [CsrIdxW-1:0] RegFooterByte = 2'd1;
   localparam logic [CsrIdxW-1:0] RegXorEnable  = 2'd2;

   // receive phases
   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN,
      PH_DATA,
      PH_EMIT
   } phase_type;

   // controller to datapath
   typedef struct packed {
      logic start_frame;
      logic take_len;
      logic take_data;
      logic emit_load;
      logic emit_run;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_hit;
      logic len_over;
      logic last_byte;
      logic frame_ok;
      logic emit_done;
   } stat_type;

endpackage

>>> src/lfpr_if.sv
interface lfpr_req_if import lfpr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfpr_rsp_if import lfpr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] frame_byte;
   logic [LenW-1:0]  frame_length;
   logic             frame_last;

   modport source (output valid, output frame_byte, output frame_length, output frame_last,
                   input ready);
   modport sink (input valid, input frame_byte, input frame_length, input frame_last,
                 output ready);
endinterface

>>> src/lfpr_ram.sv
module lfpr_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lfpr_ctrl.sv
module lfpr_ctrl import lfpr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   phase_type state_ff;
   phase_type state_in;
   logic      fire;

   // input is taken in every phase but the replay
   assign fire = req_valid && (state_ff != PH_EMIT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PH_LEN: begin
            if (fire) begin
               state_in = stat.len_over ? PH_HUNT : PH_DATA;
            end
         end
         PH_DATA: begin
            if (fire && stat.last_byte) begin
               state_in = stat.frame_ok ? PH_EMIT : PH_HUNT;
            end
         end
         PH_EMIT: begin
            if (stat.emit_done) begin
               state_in = PH_HUNT;
            end
         end
         default: begin
            if (fire && stat.start_hit) begin
               state_in = PH_LEN;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b1;
      cmd       = '0;
      case (state_ff)
         PH_LEN: begin
            cmd.take_len = fire;
         end
         PH_DATA: begin
            cmd.take_data = fire;
            cmd.emit_load = fire && stat.last_byte && stat.frame_ok;
         end
         PH_EMIT: begin
            req_ready    = 1'b0;
            cmd.emit_run = 1'b1;
         end
         default: begin
            cmd.start_frame = fire && stat.start_hit;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/lfpr_datapath.sv
module lfpr_datapath import lfpr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [ByteW-1:0]   csr_wdata,
   input  cmd_type            cmd,
   input  logic [ByteW-1:0]   rx_byte,
   output stat_type           stat,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [ByteW-1:0]   out_byte,
   output logic [LenW-1:0]    out_length,
   output logic               out_last
);

   logic [ByteW-1:0]  start_byte_ff;
   logic [ByteW-1:0]  footer_byte_ff;
   logic              xor_en_ff;
   logic [CountW-1:0] byte_count_ff;
   logic [CountW-1:0] byte_count_in;
   logic [CountW-1:0] expected_ff;
   logic [CountW-1:0] expected_in;
   logic [ByteW-1:0]  xor_ff;
   logic [ByteW-1:0]  xor_in;
   logic [ByteW-1:0]  prev_ff;
   logic [CountW-1:0] rd_idx_ff;
   logic [CountW-1:0] frame_len_ff;
   logic              rd_pend_ff;
   logic              pend_last_ff;
   logic              out_valid_ff;
   logic [ByteW-1:0]  out_byte_ff;
   logic [LenW-1:0]   out_len_ff;
   logic              out_last_ff;
   logic              wr_en;
   logic [AddrW-1:0]  wr_addr;
   logic [ByteW-1:0]  rd_data;
   logic              rd_issue;
   logic              xor_take;
   logic [ByteW:0]    len_sum;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= '0;
         footer_byte_ff <= '0;
         xor_en_ff      <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            RegStartByte:  start_byte_ff  <= csr_wdata;
            RegFooterByte: footer_byte_ff <= csr_wdata;
            RegXorEnable:  xor_en_ff      <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   // length decode and xor window
   assign len_sum  = {1'b0, rx_byte} + (ByteW+1)'(LenAdd);
   assign xor_take = (byte_count_ff >= CountW'(XorFirst)) &&
                     ({1'b0, byte_count_ff} + (CountW+1)'(TrailBytes) <= {1'b0, expected_ff});

   // status to controller
   always_comb begin
      stat.start_hit = (rx_byte == start_byte_ff);
      stat.len_over  = (len_sum > (ByteW+1)'(MaxFrame));
      stat.last_byte = (byte_count_ff + CountW'(1) == expected_ff);
      stat.frame_ok  = (rx_byte == footer_byte_ff) &&
                       (expected_ff >= CountW'(MinLen)) &&
                       (!xor_en_ff || (xor_ff == prev_ff));
      stat.emit_done = (rd_idx_ff == frame_len_ff);
   end

   // frame collection counters
   always_comb begin
      byte_count_in = byte_count_ff;
      expected_in   = expected_ff;
      xor_in        = xor_ff;
      if (cmd.start_frame) begin
         byte_count_in = CountW'(1);
         xor_in        = '0;
      end else if (cmd.take_len) begin
         byte_count_in = byte_count_ff + CountW'(1);
         expected_in   = CountW'(len_sum);
      end else if (cmd.take_data) begin
         byte_count_in = byte_count_ff + CountW'(1);
         if (xor_take) begin
            xor_in = xor_ff ^ rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         expected_ff   <= '0;
         xor_ff        <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         expected_ff   <= expected_in;
         xor_ff        <= xor_in;
      end
   end

   // previous data byte, the checksum position at frame end
   always_ff @(posedge clock) begin
      if (cmd.take_data) begin
         prev_ff <= rx_byte;
      end
   end

   // frame store
   assign wr_en   = cmd.start_frame || cmd.take_len || cmd.take_data;
   assign wr_addr = cmd.start_frame ? '0 : byte_count_ff[AddrW-1:0];

   lfpr_ram #(
      .Width (ByteW),
      .Depth (MaxFrame)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx_byte),
      .rd_addr (rd_idx_ff[AddrW-1:0]),
      .rd_data (rd_data)
   );

   // read issue only when the output register will be free on return
   assign rd_issue = cmd.emit_run && !stat.emit_done && !rd_pend_ff &&
                     (!out_valid_ff || out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         frame_len_ff <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         rd_pend_ff <= rd_issue;
         if (cmd.emit_load) begin
            rd_idx_ff    <= '0;
            frame_len_ff <= expected_ff;
         end else if (rd_issue) begin
            rd_idx_ff <= rd_idx_ff + CountW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         pend_last_ff <= (rd_idx_ff + CountW'(1) == frame_len_ff);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rd_pend_ff) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         out_byte_ff <= rd_data;
         out_len_ff  <= frame_len_ff[LenW-1:0];
         out_last_ff <= pend_last_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_byte   = out_byte_ff;
   assign out_length = out_len_ff;
   assign out_last   = out_last_ff;

endmodule

>>> src/length_framed_packet_receiver_core.sv
// channel   dir   handshake        payload
// req_bus   in    valid / ready    rx_byte
// rsp_bus   out   valid / ready    frame_byte, frame_length, frame_last
// csr_*     in    csr_we           csr_index, csr_wdata
//
// one received byte per cycle while collecting a frame
// an accepted frame is replayed from the 64-byte store one byte read at a time: a new
// read waits until the registered read data of the last one is back; no input is taken meanwhile
// synchronous active-high reset; the store needs no clearing
// rsp stalls hold the output register; the next frame may arrive behind it
module length_framed_packet_receiver_core import lfpr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   lfpr_req_if.sink           req_bus,
   lfpr_rsp_if.source         rsp_bus,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [ByteW-1:0]   csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // controller
   lfpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   lfpr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .rx_byte    (req_bus.rx_byte),
      .stat       (stat),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_byte   (rsp_bus.frame_byte),
      .out_length (rsp_bus.frame_length),
      .out_last   (rsp_bus.frame_last)
   );

   // emitted frames always meet the minimum length and fit the store
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.frame_length >= LenW'(MinLen)) &&
                        (rsp_bus.frame_length <= LenW'(MaxFrame)))
      else $error("emitted frame length out of range");

   // a good frame end stops input for the replay
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |=> !req_bus.ready && cmd.emit_run)
      else $error("replay did not start after a good frame");

   // replay ends once all reads are issued
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_run && stat.emit_done |=> !cmd.emit_run)
      else $error("replay did not stop after the last read");

endmodule

>>> tb/lfpr_scoreboard_pkg.sv
package lfpr_tb_pkg;
   import lfpr_pkg::*;

   // one output transaction of an accepted frame
   typedef struct packed {
      logic [ByteW-1:0] data;
      logic [LenW-1:0]  length;
      logic             last;
   } frame_beat_type;

   class frame_scoreboard;
      // register copies
      logic [ByteW-1:0] start_val;
      logic [ByteW-1:0] footer_val;
      logic             xor_on;

      // receive state
      phase_type        phase;
      int unsigned      byte_count;
      logic [8:0]       want_len;
      logic [ByteW-1:0] xor_acc;
      logic [ByteW-1:0] frame_mem [MaxFrame];

      // beats of accepted frames still to come out
      frame_beat_type   frame_q[$];
      int               errors;

      function new();
         start_val  = '0;
         footer_val = '0;
         xor_on     = 1'b1;
         errors     = 0;
         drop_frame();
      endfunction

      function void drop_frame();
         phase      = PH_HUNT;
         byte_count = 0;
         want_len   = '0;
         xor_acc    = '0;
      endfunction

      function void store_byte(logic [ByteW-1:0] b);
         if (byte_count < MaxFrame) begin
            frame_mem[byte_count] = b;
         end
         byte_count++;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [ByteW-1:0] data);
         case (idx)
            RegStartByte:  start_val  = data;
            RegFooterByte: footer_val = data;
            RegXorEnable:  xor_on     = data[0];
            default: ;
         endcase
      endfunction

      // advance the receive state by one accepted input transaction
      function void note_rx_byte(logic [ByteW-1:0] b);
         int unsigned    len;
         bit             ok;
         frame_beat_type beat;
         if (phase == PH_LEN) begin
            store_byte(b);
            want_len = 9'(b) + 9'(LenAdd);
            if (want_len > MaxFrame) begin
               drop_frame();
            end else begin
               phase = PH_DATA;
            end
         end else if (phase == PH_DATA) begin
            if (byte_count >= XorFirst && byte_count + TrailBytes <= want_len) begin
               xor_acc ^= b;
            end
            store_byte(b);
            if (byte_count >= want_len) begin
               // frame complete: footer, minimum length, optional xor check
               len = want_len;
               ok  = (frame_mem[len-1] == footer_val) && (len >= MinLen);
               if (ok && xor_on) begin
                  ok = (xor_acc == frame_mem[len-2]);
               end
               drop_frame();
               if (ok) begin
                  for (int unsigned i = 0; i < len; i++) begin
                     beat.data   = frame_mem[i];
                     beat.length = LenW'(len);
                     beat.last   = (i + 1 == len);
                     frame_q.push_back(beat);
                  end
               end
            end
         end else if (b == start_val) begin
            // hunting, including the unused phase code
            byte_count = 0;
            xor_acc    = '0;
            store_byte(b);
            phase      = PH_LEN;
         end
      endfunction

      // compare one output transaction with the oldest expected beat
      function void check_frame_beat(logic [ByteW-1:0] data, logic [LenW-1:0] length,
                                     logic last);
         frame_beat_type want;
         if (frame_q.size() == 0) begin
            $display("%0t: unexpected frame byte %02h len %0d last %0b", $time, data, length,
                     last);
            errors++;
         end else begin
            want = frame_q.pop_front();
            if (data !== want.data) begin
               $display("%0t: frame_byte expected %02h, actual %02h", $time, want.data, data);
               errors++;
            end
            if (length !== want.length) begin
               $display("%0t: frame_length expected %0d, actual %0d", $time, want.length,
                        length);
               errors++;
            end
            if (last !== want.last) begin
               $display("%0t: frame_last expected %0b, actual %0b", $time, want.last, last);
               errors++;
            end
         end
      endfunction
   endclass

endpackage

>>> tb/tb_top.sv
module tb_top;
   import lfpr_pkg::*;
   import lfpr_tb_pkg::*;

   localparam logic [CsrIdxW-1:0] RegSpare = 2'd3;
   localparam int CycleLimit = 200000;

   typedef enum {
      FR_GOOD,
      FR_BAD_FOOTER,
      FR_BAD_XOR,
      FR_SHORT,
      FR_OVERSIZE,
      FR_CUT,
      FR_NOISE
   } frame_kind_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [ByteW-1:0]   csr_wdata;

   lfpr_req_if req ();
   lfpr_rsp_if rsp ();

   frame_scoreboard sb;
   bit              calm = 1'b0;
   int              items_sent = 0;
   int              cycle_count = 0;
   logic [ByteW-1:0] corner_payload [7] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55};

   length_framed_packet_receiver_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req),
      .rsp_bus   (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side back-pressure
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= calm || ($urandom_range(0, 99) >= 7);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         sb.check_frame_beat(rsp.frame_byte, rsp.frame_length, rsp.frame_last);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  sb.frame_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // one register write, entered and left at a falling edge
   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [ByteW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [ByteW-1:0] start_b, input logic [ByteW-1:0] foot_b,
                               input logic xor_en);
      csr_write(RegStartByte, start_b);
      csr_write(RegFooterByte, foot_b);
      // upper bits are don't-care for the enable
      csr_write(RegXorEnable, {7'($urandom), xor_en});
      csr_we <= 1'b0;
   endtask

   // one input transaction with optional idle cycles ahead of it
   task automatic send_byte(input logic [ByteW-1:0] b);
      while (!calm && $urandom_range(0, 99) < 7) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid   <= 1'b1;
      req.rx_byte <= b;
      do @(posedge clock); while (!req.ready);
      if (sb.phase != PH_HUNT || b == sb.start_val) begin
         items_sent++;
      end
      sb.note_rx_byte(b);
      @(negedge clock);
   endtask

   task automatic send_frame(input frame_kind_type kind, input int unsigned len);
      logic [ByteW-1:0] b;
      logic [ByteW-1:0] sum;
      int unsigned      stop_at;
      int unsigned      i;
      sum = '0;
      case (kind)
         FR_NOISE: begin
            b = 8'($urandom);
            if (b == sb.start_val) begin
               b = ~b;
            end
            send_byte(b);
         end
         FR_OVERSIZE: begin
            send_byte(sb.start_val);
            send_byte(8'($urandom_range(MaxFrame - LenAdd + 1, 255)));
         end
         default: begin
            // cut frames stop early and the next bytes land inside them
            stop_at = (kind == FR_CUT) ? $urandom_range(2, len - 1) : len;
            for (i = 0; i < stop_at; i++) begin
               if (i == 0) begin
                  b = sb.start_val;
               end else if (i == 1) begin
                  b = 8'(len - LenAdd);
               end else if (i == len - 2) begin
                  b = (kind == FR_BAD_XOR) ? sum ^ 8'($urandom_range(1, 255)) : sum;
               end else if (i == len - 1) begin
                  b = (kind == FR_BAD_FOOTER) ? sb.footer_val ^ 8'($urandom_range(1, 255))
                                              : sb.footer_val;
               end else begin
                  b = 8'($urandom);
                  sum ^= b;
               end
               send_byte(b);
            end
         end
      endcase
   endtask

   // mostly well-formed frames, some broken ones and line noise
   task automatic run_random(input int quota);
      int             stop_at;
      int             pick;
      frame_kind_type kind;
      int unsigned    len;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)      kind = FR_GOOD;
         else if (pick < 63) kind = FR_BAD_FOOTER;
         else if (pick < 71) kind = FR_BAD_XOR;
         else if (pick < 78) kind = FR_SHORT;
         else if (pick < 85) kind = FR_OVERSIZE;
         else if (pick < 91) kind = FR_CUT;
         else                kind = FR_NOISE;
         if (kind == FR_SHORT) begin
            len = $urandom_range(LenAdd, MinLen - 1);
         end else if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(MinLen + 8, MaxFrame);
         end else begin
            len = $urandom_range(MinLen, MinLen + 7);
         end
         send_frame(kind, len);
      end
   endtask

   // finish any open frame, then hold off until every beat is out
   task automatic drain();
      while (sb.phase != PH_HUNT) begin
         send_byte((sb.phase == PH_LEN) ? 8'hFF : 8'($urandom));
      end
      req.valid <= 1'b0;
      while (sb.frame_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      @(negedge clock);
   endtask

   // main sequence
   initial begin
      logic [ByteW-1:0] xacc;
      sb          = new();
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = RegStartByte;
      csr_wdata   = '0;
      req.valid   = 1'b0;
      req.rx_byte = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: footer equals start, to show that frame ends are not taken as starts
      program_regs(8'hF0, 8'hF0, 1'b1);
      xacc = '0;
      send_byte(8'hF0);
      send_byte(8'(MinLen - LenAdd));
      foreach (corner_payload[i]) begin
         send_byte(corner_payload[i]);
         xacc ^= corner_payload[i];
      end
      send_byte(xacc);
      send_byte(8'hF0);
      // oversized length equal to the start byte, then the largest length
      send_byte(8'hF0);
      send_byte(8'hF0);
      send_byte(8'hF0);
      send_byte(8'hFF);
      // one past the largest frame
      send_byte(8'hF0);
      send_byte(8'(MaxFrame - LenAdd + 1));
      // shortest possible frame, well formed but too short
      send_byte(8'hF0);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hF0);
      drain();

      // extremes, xor check off, largest frame first
      program_regs(8'h00, 8'hFF, 1'b0);
      send_frame(FR_GOOD, MaxFrame);
      run_random(30);
      drain();

      // opposite extremes with no idling on either side
      calm = 1'b1;
      program_regs(8'hFF, 8'h00, 1'b1);
      run_random(20);
      drain();
      calm = 1'b0;

      // unused index, then random settings
      csr_write(RegSpare, 8'($urandom));
      program_regs(8'($urandom), 8'($urandom), 1'($urandom));
      run_random(20);
      drain();

      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
